[src/nmea_sentence_checker_core_macros.svh]
// ---------------------------------------------------------------------------
// nmea sentence checker assertion macros
// concurrent checks clocked on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_CORE_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define NSC_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nmea checker assertion failed");

// next-cycle implication
`define NSC_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nmea checker assertion failed");

`endif

[src/nmea_sc_pkg.sv]
// ---------------------------------------------------------------------------
// nmea_sc_pkg
// shared types, character codes and lookup functions of the sentence checker
// ---------------------------------------------------------------------------
package nmea_sc_pkg;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;

   // type letters, first letter in the low byte
   localparam logic [23:0] TYPE_GSV = 24'h56_53_47;
   localparam logic [23:0] TYPE_GSA = 24'h41_53_47;
   localparam logic [23:0] TYPE_GGA = 24'h41_47_47;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_DOLLAR = 3'd1;
   localparam logic [2:0] ST_NO_STAR  = 3'd2;
   localparam logic [2:0] ST_BAD_HEX  = 3'd3;
   localparam logic [2:0] ST_MISMATCH = 3'd4;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_GSV   = 2'd1;
   localparam logic [1:0] KIND_GSA   = 2'd2;
   localparam logic [1:0] KIND_GGA   = 2'd3;

   localparam logic [2:0] TALK_GP = 3'd0;
   localparam logic [2:0] TALK_GL = 3'd1;
   localparam logic [2:0] TALK_GA = 3'd2;
   localparam logic [2:0] TALK_BD = 3'd3;
   localparam logic [2:0] TALK_GQ = 3'd4;
   localparam logic [2:0] TALK_GN = 3'd5;

   localparam int FIELD_CHAR_LIMIT = 15;

   typedef struct packed {
      logic [7:0] value;
      logic       nonempty;
      logic       run;
      logic [3:0] count;
   } acc_type;

   typedef struct packed {
      logic [7:0] computed_sum;
      logic [7:0] key_value;
      logic       key_present;
      logic [2:0] talker;
      logic [1:0] sentence_kind;
      logic [2:0] status;
   } result_type;

   localparam acc_type ACC_CLEAR = '{value: 8'd0, nonempty: 1'b0, run: 1'b1, count: 4'd0};

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CH_0 && c <= CH_9) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF_HEX)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // {found, index}
   function automatic logic [3:0] talker_lookup(input logic [7:0] t0, input logic [7:0] t1);
      logic [3:0] r;
      case ({t0, t1})
         16'h4750: r = {1'b1, TALK_GP};
         16'h474C: r = {1'b1, TALK_GL};
         16'h4741: r = {1'b1, TALK_GA};
         16'h4244: r = {1'b1, TALK_BD};
         16'h4751: r = {1'b1, TALK_GQ};
         16'h474E: r = {1'b1, TALK_GN};
         default:  r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic acc_type acc_feed(input acc_type a, input logic [7:0] c);
      acc_type    r;
      logic [11:0] v;
      logic       dig;
      r = a;
      dig = (c >= CH_0) && (c <= CH_9);
      v = {4'd0, a.value} * 12'd10 + {8'd0, c[3:0]};
      r.nonempty = 1'b1;
      if (a.run && (a.count < 4'(FIELD_CHAR_LIMIT)) && dig) begin
         r.value = (v > 12'd255) ? 8'hFF : v[7:0];
      end else begin
         r.run = 1'b0;
      end
      if (a.count < 4'(FIELD_CHAR_LIMIT)) begin
         r.count = a.count + 4'd1;
      end
      return r;
   endfunction

endpackage

[src/nmea_sc_line.sv]
// ---------------------------------------------------------------------------
// nmea_sc_line
// per-line running state, updated one byte per step, and the result word
// ---------------------------------------------------------------------------
module nmea_sc_line #(
   parameter int LINE_CAPACITY = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   output logic                   result_valid,
   output nmea_sc_pkg::result_type result
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_CAPACITY - 1);
   localparam logic [CNT_W-1:0] PREFIX_LAST = CNT_W'(5);

   typedef struct packed {
      logic                 content_ended;
      logic                 has_content;
      logic                 starts_with_dollar;
      logic [7:0]           running_xor;
      logic                 star_seen;
      logic [1:0]           chars_after_star;
      logic [7:0]           received_sum;
      logic                 hex_ok;
      logic [39:0]          prefix_chars;
      logic [2:0]           field_number;
      nmea_sc_pkg::acc_type field_two_value;
      nmea_sc_pkg::acc_type field_six_value;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{
      content_ended: 1'b0, has_content: 1'b0, starts_with_dollar: 1'b0,
      running_xor: 8'd0, star_seen: 1'b0, chars_after_star: 2'd0,
      received_sum: 8'd0, hex_ok: 1'b1, prefix_chars: 40'd0, field_number: 3'd0,
      field_two_value: nmea_sc_pkg::ACC_CLEAR, field_six_value: nmea_sc_pkg::ACC_CLEAR};

   line_state_type   line_ff, line_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic       is_cr, is_nl, do_store, do_process;
   logic [4:0] hex;
   logic [2:0] lane;

   assign is_cr      = (rx_byte == nmea_sc_pkg::CH_CR);
   assign is_nl      = (rx_byte == nmea_sc_pkg::CH_LF);
   assign do_store   = step && !is_cr && !is_nl && (count_ff < CNT_MAX);
   assign do_process = do_store && (rx_byte != nmea_sc_pkg::CH_NUL) && !line_ff.content_ended;
   assign hex        = nmea_sc_pkg::hex_decode(rx_byte);
   assign lane       = count_ff[2:0] - 3'd1;

   always_comb begin
      line_in  = line_ff;
      count_in = count_ff;
      if (step && is_nl) begin
         line_in  = LINE_CLEAR;
         count_in = '0;
      end else if (do_store) begin
         count_in = count_ff + CNT_W'(1);
         if (rx_byte == nmea_sc_pkg::CH_NUL) begin
            line_in.content_ended = 1'b1;
         end
         if (do_process) begin
            if (count_ff == '0) begin
               line_in.has_content        = 1'b1;
               line_in.starts_with_dollar = (rx_byte == nmea_sc_pkg::CH_DOLLAR);
            end else if (line_ff.star_seen) begin
               if (line_ff.chars_after_star < 2'd2) begin
                  if (!hex[4]) begin
                     line_in.hex_ok = 1'b0;
                  end else begin
                     line_in.received_sum = {line_ff.received_sum[3:0], hex[3:0]};
                  end
                  line_in.chars_after_star = line_ff.chars_after_star + 2'd1;
               end
            end else if (rx_byte == nmea_sc_pkg::CH_STAR) begin
               line_in.star_seen = 1'b1;
            end else begin
               line_in.running_xor = line_ff.running_xor ^ rx_byte;
               // characters 2..6 of the line land in byte lanes 0..4
               if (count_ff <= PREFIX_LAST) begin
                  for (int i = 0; i < 5; i++) begin
                     if (lane == 3'(i)) begin
                        line_in.prefix_chars[i*8 +: 8] = rx_byte;
                     end
                  end
               end
               if (rx_byte == nmea_sc_pkg::CH_COMMA) begin
                  if (line_ff.field_number != 3'd7) begin
                     line_in.field_number = line_ff.field_number + 3'd1;
                  end
               end else if (line_ff.field_number == 3'd2) begin
                  line_in.field_two_value = nmea_sc_pkg::acc_feed(line_ff.field_two_value, rx_byte);
               end else if (line_ff.field_number == 3'd6) begin
                  line_in.field_six_value = nmea_sc_pkg::acc_feed(line_ff.field_six_value, rx_byte);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= LINE_CLEAR;
         count_ff <= '0;
      end else begin
         line_ff  <= line_in;
         count_ff <= count_in;
      end
   end

   // result from the state as it stands when the newline arrives
   logic [3:0]  talk_hit;
   logic [23:0] type_chars;

   assign talk_hit     = nmea_sc_pkg::talker_lookup(line_ff.prefix_chars[7:0],
                                                    line_ff.prefix_chars[15:8]);
   assign type_chars   = line_ff.prefix_chars[39:16];
   assign result_valid = step && is_nl && line_ff.has_content;

   always_comb begin
      result = '0;
      result.computed_sum = line_ff.running_xor;
      if (!line_ff.starts_with_dollar) begin
         result.status = nmea_sc_pkg::ST_NO_DOLLAR;
      end else if (!line_ff.star_seen || line_ff.chars_after_star < 2'd2) begin
         result.status = nmea_sc_pkg::ST_NO_STAR;
      end else if (!line_ff.hex_ok) begin
         result.status = nmea_sc_pkg::ST_BAD_HEX;
      end else if (line_ff.received_sum != line_ff.running_xor) begin
         result.status = nmea_sc_pkg::ST_MISMATCH;
      end else begin
         result.status = nmea_sc_pkg::ST_OK;
      end
      if (result.status == nmea_sc_pkg::ST_OK && talk_hit[3]) begin
         if (type_chars == nmea_sc_pkg::TYPE_GSV) begin
            result.sentence_kind = nmea_sc_pkg::KIND_GSV;
         end else if (type_chars == nmea_sc_pkg::TYPE_GSA) begin
            result.sentence_kind = nmea_sc_pkg::KIND_GSA;
         end else if (type_chars == nmea_sc_pkg::TYPE_GGA &&
                      (talk_hit[2:0] == nmea_sc_pkg::TALK_GP ||
                       talk_hit[2:0] == nmea_sc_pkg::TALK_GN)) begin
            result.sentence_kind = nmea_sc_pkg::KIND_GGA;
         end
         if (result.sentence_kind != nmea_sc_pkg::KIND_OTHER) begin
            result.talker = talk_hit[2:0];
         end
         if (result.sentence_kind == nmea_sc_pkg::KIND_GSA) begin
            result.key_present = line_ff.field_two_value.nonempty;
            result.key_value   = line_ff.field_two_value.value;
         end else if (result.sentence_kind == nmea_sc_pkg::KIND_GGA) begin
            result.key_present = line_ff.field_six_value.nonempty;
            result.key_value   = line_ff.field_six_value.value;
         end
      end
   end

endmodule

[src/nmea_sentence_checker_core.sv]
// ---------------------------------------------------------------------------
// nmea_sentence_checker_core: nmea 0183 line parser and checksum checker
// one byte accepted per cycle while the result register is not stalled;
// a newline's result passes the input register, then the result register
// reset (synchronous) empties both registers and clears the line state
// ---------------------------------------------------------------------------
`include "nmea_sentence_checker_core_macros.svh"

module nmea_sentence_checker_core #(
   parameter int LINE_CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [4:3] sentence_kind, [7:5] talker, [8] key_present,
   // [16:9] key_value, [24:17] computed_sum, [31:25] zero
   output logic [31:0] rsp_tdata
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   nmea_sc_pkg::result_type rsp_data_ff;

   logic advance, step, res_valid;
   nmea_sc_pkg::result_type res;

   // the result register frees up when empty or taken this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? (step && res_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   nmea_sc_line #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_line (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .result_valid (res_valid),
      .result       (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   `NSC_CHECK(a_rejected_has_no_kind, rsp_valid_ff && rsp_data_ff.status != nmea_sc_pkg::ST_OK, rsp_data_ff.sentence_kind == nmea_sc_pkg::KIND_OTHER)
   `NSC_CHECK(a_other_kind_zero_fields, rsp_valid_ff && rsp_data_ff.sentence_kind == nmea_sc_pkg::KIND_OTHER, rsp_data_ff.talker == 3'd0 && !rsp_data_ff.key_present && rsp_data_ff.key_value == 8'd0)
   `NSC_CHECK(a_status_in_range, rsp_valid_ff, rsp_data_ff.status <= nmea_sc_pkg::ST_MISMATCH)
   `NSC_CHECK_NEXT(a_input_held_on_stall, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule
